### hdl/u8ds_pkg.sv
// Shared types, constants and the second-byte table for the UTF-8 diacritic stripper.
package u8ds_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned SKIP_W = 2;

    localparam logic [CHAR_W-1:0] REPL_RESET = 7'h3F;  // '?'

    // Lead bytes that start a two-byte Slovak or Czech letter
    localparam logic [BYTE_W-1:0] LEAD_BYTE_C3 = 8'hC3;
    localparam logic [BYTE_W-1:0] LEAD_BYTE_C4 = 8'hC4;
    localparam logic [BYTE_W-1:0] LEAD_BYTE_C5 = 8'hC5;

    // Lead byte class masks
    localparam logic [BYTE_W-1:0] MASK_2BYTE = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_2BYTE  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_3BYTE = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_3BYTE  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_4BYTE = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_4BYTE  = 8'hF0;

    localparam logic [SKIP_W-1:0] SKIP_NONE  = 2'd0;
    localparam logic [SKIP_W-1:0] SKIP_ONE   = 2'd1;
    localparam logic [SKIP_W-1:0] SKIP_TWO   = 2'd2;
    localparam logic [SKIP_W-1:0] SKIP_THREE = 2'd3;

    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_C3   = 2'd1,
        LEAD_C4   = 2'd2,
        LEAD_C5   = 2'd3
    } lead_t;

    // Parser state carried from one byte to the next
    typedef struct packed {
        lead_t             lead;
        logic [SKIP_W-1:0] skip;
    } parse_state_t;

    // Decoder verdict for one byte
    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] ch;
        parse_state_t      next;
    } decode_t;

    // Map the byte after a held lead to its base letter
    function automatic logic [CHAR_W-1:0] map_second(
        input lead_t             lead,
        input logic [BYTE_W-1:0] b,
        input logic [CHAR_W-1:0] repl
    );
        logic [CHAR_W-1:0] ch;
        ch = repl;
        case (lead)
            LEAD_C3:
            begin
                case (b)
                    8'hA1, 8'hA4: ch = 7'h61;  // a
                    8'h81, 8'h84: ch = 7'h41;  // A
                    8'hA9:        ch = 7'h65;  // e
                    8'h89:        ch = 7'h45;  // E
                    8'hAD:        ch = 7'h69;  // i
                    8'h8D:        ch = 7'h49;  // I
                    8'hB3, 8'hB4: ch = 7'h6F;  // o
                    8'h93, 8'h94: ch = 7'h4F;  // O
                    8'hBA:        ch = 7'h75;  // u
                    8'h9A:        ch = 7'h55;  // U
                    8'hBD:        ch = 7'h79;  // y
                    8'h9D:        ch = 7'h59;  // Y
                    default:      ch = repl;
                endcase
            end
            LEAD_C4:
            begin
                case (b)
                    8'h8D:        ch = 7'h63;  // c
                    8'h8C:        ch = 7'h43;  // C
                    8'h8F:        ch = 7'h64;  // d
                    8'h8E:        ch = 7'h44;  // D
                    8'hBE, 8'hBA: ch = 7'h6C;  // l
                    8'hBD, 8'hB9: ch = 7'h4C;  // L
                    default:      ch = repl;
                endcase
            end
            LEAD_C5:
            begin
                case (b)
                    8'h88:   ch = 7'h6E;  // n
                    8'h87:   ch = 7'h4E;  // N
                    8'h95:   ch = 7'h72;  // r
                    8'h94:   ch = 7'h52;  // R
                    8'hA1:   ch = 7'h73;  // s
                    8'hA0:   ch = 7'h53;  // S
                    8'hA5:   ch = 7'h74;  // t
                    8'hA4:   ch = 7'h54;  // T
                    8'hBE:   ch = 7'h7A;  // z
                    8'hBD:   ch = 7'h5A;  // Z
                    default: ch = repl;
                endcase
            end
            default: ch = repl;
        endcase
        return ch;
    endfunction

endpackage

### hdl/u8ds_decode.sv
// Per-byte decoder: next parser state and optional output character.
module u8ds_decode (
    input  logic [u8ds_pkg::BYTE_W-1:0] byte_in,
    input  u8ds_pkg::parse_state_t      state,
    input  logic [u8ds_pkg::CHAR_W-1:0] repl,
    output u8ds_pkg::decode_t           dec
);

    // Classify the byte against the held state
    always_comb
    begin
        dec.emit = 1'b0;
        dec.ch   = repl;
        dec.next = state;
        if (byte_in == '0)
        begin
            // terminator: emit zero and drop anything pending
            dec.emit      = 1'b1;
            dec.ch        = '0;
            dec.next.lead = u8ds_pkg::LEAD_NONE;
            dec.next.skip = u8ds_pkg::SKIP_NONE;
        end
        else if (state.skip != u8ds_pkg::SKIP_NONE)
        begin
            // swallow a continuation byte
            dec.next.skip = state.skip - u8ds_pkg::SKIP_ONE;
        end
        else if (state.lead != u8ds_pkg::LEAD_NONE)
        begin
            dec.emit      = 1'b1;
            dec.ch        = u8ds_pkg::map_second(state.lead, byte_in, repl);
            dec.next.lead = u8ds_pkg::LEAD_NONE;
        end
        else if (!byte_in[u8ds_pkg::BYTE_W-1])
        begin
            dec.emit = 1'b1;
            dec.ch   = byte_in[u8ds_pkg::CHAR_W-1:0];
        end
        else if (byte_in == u8ds_pkg::LEAD_BYTE_C3)
        begin
            dec.next.lead = u8ds_pkg::LEAD_C3;
        end
        else if (byte_in == u8ds_pkg::LEAD_BYTE_C4)
        begin
            dec.next.lead = u8ds_pkg::LEAD_C4;
        end
        else if (byte_in == u8ds_pkg::LEAD_BYTE_C5)
        begin
            dec.next.lead = u8ds_pkg::LEAD_C5;
        end
        else
        begin
            // unsupported lead or stray byte: replace and skip its tail
            dec.emit = 1'b1;
            dec.ch   = repl;
            if ((byte_in & u8ds_pkg::MASK_2BYTE) == u8ds_pkg::PAT_2BYTE)
                dec.next.skip = u8ds_pkg::SKIP_ONE;
            else if ((byte_in & u8ds_pkg::MASK_3BYTE) == u8ds_pkg::PAT_3BYTE)
                dec.next.skip = u8ds_pkg::SKIP_TWO;
            else if ((byte_in & u8ds_pkg::MASK_4BYTE) == u8ds_pkg::PAT_4BYTE)
                dec.next.skip = u8ds_pkg::SKIP_THREE;
            else
                dec.next.skip = u8ds_pkg::SKIP_NONE;
        end
    end

endmodule

### hdl/utf8_diacritic_stripper.sv
// Top level of the UTF-8 to ASCII diacritic stripper.
// Takes one UTF-8 byte per beat on in_byte and gives at most one ASCII
// character per beat on ascii_char. Slovak and Czech letters (lead byte C3,
// C4 or C5 plus one byte) become their base letter; anything else outside
// ASCII becomes the replacement character, written through cfg_wr_en and
// cfg_wr_data (reset '?'), and the tail bytes of such a sequence are dropped.
// A zero byte ends the string, gives 0 and clears any pending sequence. The
// block takes one byte per clock while the output is not stalled: a byte is
// registered on entry, decoded by a single level of table logic against the
// two-bit lead and skip state, and the character lands in an output register.
// Supported lead bytes (C3, C4, C5) and tail bytes produce no output beat.
module utf8_diacritic_stripper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [u8ds_pkg::CHAR_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8ds_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8ds_pkg::CHAR_W-1:0]   ascii_char
);

    logic [u8ds_pkg::CHAR_W-1:0] repl_reg;
    logic                        byte_valid_reg;
    logic [u8ds_pkg::BYTE_W-1:0] byte_reg;
    u8ds_pkg::parse_state_t      state_reg;
    logic                        out_valid_reg;
    logic [u8ds_pkg::CHAR_W-1:0] char_reg;

    u8ds_pkg::decode_t dec;
    logic              out_free;
    logic              stage_fire;

    // Hold the replacement character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= u8ds_pkg::REPL_RESET;
        else if (cfg_wr_en)
            repl_reg <= cfg_wr_data;
    end

    u8ds_decode u_decode (
        .byte_in (byte_reg),
        .state   (state_reg),
        .repl    (repl_reg),
        .dec     (dec)
    );

    // Advance the held byte when its result, if any, has a place to go
    assign out_free   = !out_valid_reg || out_ready;
    assign stage_fire = byte_valid_reg && (!dec.emit || out_free);
    assign in_ready   = !byte_valid_reg || stage_fire;

    // Input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.lead <= u8ds_pkg::LEAD_NONE;
            state_reg.skip <= u8ds_pkg::SKIP_NONE;
        end
        else if (stage_fire)
        begin
            state_reg <= dec.next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stage_fire && dec.emit;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_fire && dec.emit)
            char_reg <= dec.ch;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;

`ifndef SYNTH
    // A held lead and a pending skip never coexist
    a_lead_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !((state_reg.lead != u8ds_pkg::LEAD_NONE) &&
          (state_reg.skip != u8ds_pkg::SKIP_NONE)))
        else $error("lead and skip pending together");

    // A terminator clears all parser state
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && (byte_reg == '0)) |=>
        (state_reg.lead == u8ds_pkg::LEAD_NONE) &&
        (state_reg.skip == u8ds_pkg::SKIP_NONE))
        else $error("terminator left state pending");

    // An emitting byte shows up at the output next cycle
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && dec.emit) |=>
        (out_valid_reg && (char_reg == $past(dec.ch))))
        else $error("decoded character lost");

    // Swallowed bytes produce no output
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid_reg && (state_reg.skip != u8ds_pkg::SKIP_NONE) &&
         (byte_reg != '0)) |-> !dec.emit)
        else $error("skipped byte emitted");
`endif

endmodule

### test/tb_utf8_diacritic_stripper.sv
// Self-checking testbench for the UTF-8 to ASCII diacritic stripper.
`timescale 1ns / 100ps

// Predicts the character stream of the stripper and checks the output beats
class translit_scoreboard;
    logic [u8ds_pkg::CHAR_W-1:0] repl;
    u8ds_pkg::lead_t             held_lead;
    logic [u8ds_pkg::SKIP_W-1:0] tail_left;
    logic [u8ds_pkg::CHAR_W-1:0] pending_chars [$];
    int                          errors;
    int                          checked;

    function new();
        repl      = u8ds_pkg::REPL_RESET;
        held_lead = u8ds_pkg::LEAD_NONE;
        tail_left = u8ds_pkg::SKIP_NONE;
        errors    = 0;
        checked   = 0;
    endfunction

    function void set_repl(logic [u8ds_pkg::CHAR_W-1:0] value);
        repl = value;
    endfunction

    // Base letter for a held lead and its second byte
    function logic [u8ds_pkg::CHAR_W-1:0] base_letter(u8ds_pkg::lead_t l,
                                                      logic [u8ds_pkg::BYTE_W-1:0] b);
        logic [u8ds_pkg::BYTE_W-1:0] letter;
        letter = {1'b0, repl};
        case ({l, b})
            {u8ds_pkg::LEAD_C3, 8'hA1}, {u8ds_pkg::LEAD_C3, 8'hA4}: letter = "a";
            {u8ds_pkg::LEAD_C3, 8'h81}, {u8ds_pkg::LEAD_C3, 8'h84}: letter = "A";
            {u8ds_pkg::LEAD_C3, 8'hA9}:                             letter = "e";
            {u8ds_pkg::LEAD_C3, 8'h89}:                             letter = "E";
            {u8ds_pkg::LEAD_C3, 8'hAD}:                             letter = "i";
            {u8ds_pkg::LEAD_C3, 8'h8D}:                             letter = "I";
            {u8ds_pkg::LEAD_C3, 8'hB3}, {u8ds_pkg::LEAD_C3, 8'hB4}: letter = "o";
            {u8ds_pkg::LEAD_C3, 8'h93}, {u8ds_pkg::LEAD_C3, 8'h94}: letter = "O";
            {u8ds_pkg::LEAD_C3, 8'hBA}:                             letter = "u";
            {u8ds_pkg::LEAD_C3, 8'h9A}:                             letter = "U";
            {u8ds_pkg::LEAD_C3, 8'hBD}:                             letter = "y";
            {u8ds_pkg::LEAD_C3, 8'h9D}:                             letter = "Y";
            {u8ds_pkg::LEAD_C4, 8'h8D}:                             letter = "c";
            {u8ds_pkg::LEAD_C4, 8'h8C}:                             letter = "C";
            {u8ds_pkg::LEAD_C4, 8'h8F}:                             letter = "d";
            {u8ds_pkg::LEAD_C4, 8'h8E}:                             letter = "D";
            {u8ds_pkg::LEAD_C4, 8'hBE}, {u8ds_pkg::LEAD_C4, 8'hBA}: letter = "l";
            {u8ds_pkg::LEAD_C4, 8'hBD}, {u8ds_pkg::LEAD_C4, 8'hB9}: letter = "L";
            {u8ds_pkg::LEAD_C5, 8'h88}:                             letter = "n";
            {u8ds_pkg::LEAD_C5, 8'h87}:                             letter = "N";
            {u8ds_pkg::LEAD_C5, 8'h95}:                             letter = "r";
            {u8ds_pkg::LEAD_C5, 8'h94}:                             letter = "R";
            {u8ds_pkg::LEAD_C5, 8'hA1}:                             letter = "s";
            {u8ds_pkg::LEAD_C5, 8'hA0}:                             letter = "S";
            {u8ds_pkg::LEAD_C5, 8'hA5}:                             letter = "t";
            {u8ds_pkg::LEAD_C5, 8'hA4}:                             letter = "T";
            {u8ds_pkg::LEAD_C5, 8'hBE}:                             letter = "z";
            {u8ds_pkg::LEAD_C5, 8'hBD}:                             letter = "Z";
            default:                                                letter = {1'b0, repl};
        endcase
        return letter[u8ds_pkg::CHAR_W-1:0];
    endfunction

    // Advance the parser by one accepted byte and queue any character it gives
    function void take_byte(logic [u8ds_pkg::BYTE_W-1:0] b);
        // terminator clears everything, even mid-sequence
        if (b == '0)
        begin
            held_lead = u8ds_pkg::LEAD_NONE;
            tail_left = u8ds_pkg::SKIP_NONE;
            pending_chars.push_back('0);
            return;
        end
        // drop tail bytes of an unsupported sequence
        if (tail_left != u8ds_pkg::SKIP_NONE)
        begin
            tail_left = tail_left - u8ds_pkg::SKIP_ONE;
            return;
        end
        // second byte after a held lead is always consumed
        if (held_lead != u8ds_pkg::LEAD_NONE)
        begin
            pending_chars.push_back(base_letter(held_lead, b));
            held_lead = u8ds_pkg::LEAD_NONE;
            return;
        end
        if (!b[u8ds_pkg::BYTE_W-1])
        begin
            pending_chars.push_back(b[u8ds_pkg::CHAR_W-1:0]);
            return;
        end
        if (b == u8ds_pkg::LEAD_BYTE_C3)
            held_lead = u8ds_pkg::LEAD_C3;
        else if (b == u8ds_pkg::LEAD_BYTE_C4)
            held_lead = u8ds_pkg::LEAD_C4;
        else if (b == u8ds_pkg::LEAD_BYTE_C5)
            held_lead = u8ds_pkg::LEAD_C5;
        else
        begin
            if ((b & u8ds_pkg::MASK_2BYTE) == u8ds_pkg::PAT_2BYTE)
                tail_left = u8ds_pkg::SKIP_ONE;
            else if ((b & u8ds_pkg::MASK_3BYTE) == u8ds_pkg::PAT_3BYTE)
                tail_left = u8ds_pkg::SKIP_TWO;
            else if ((b & u8ds_pkg::MASK_4BYTE) == u8ds_pkg::PAT_4BYTE)
                tail_left = u8ds_pkg::SKIP_THREE;
            else
                tail_left = u8ds_pkg::SKIP_NONE;
            pending_chars.push_back(repl);
        end
    endfunction

    // Compare one output beat with the oldest expected character
    function void check_char(logic [u8ds_pkg::CHAR_W-1:0] got);
        logic [u8ds_pkg::CHAR_W-1:0] want;
        if (pending_chars.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR %0t: unexpected output beat ascii_char=0x%02h",
                         $realtime, got);
            return;
        end
        want = pending_chars.pop_front();
        checked++;
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR %0t: ascii_char expected 0x%02h got 0x%02h",
                         $realtime, want, got);
        end
    endfunction
endclass

module tb_utf8_diacritic_stripper;

    localparam int                          CYCLE_LIMIT   = 400000;
    localparam int                          SETTLE_CYCLES = 4;
    localparam int                          PHASE_BYTES   = 170;
    localparam logic [u8ds_pkg::CHAR_W-1:0] REPL_MIN      = 7'h00;
    localparam logic [u8ds_pkg::CHAR_W-1:0] REPL_MAX      = 7'h7F;
    localparam logic [u8ds_pkg::BYTE_W-1:0] END_OF_STRING = 8'h00;

    // Second bytes that the letter table knows, one byte per slot
    localparam logic [127:0] C3_TAILS = 128'hA1A48184A989AD8DB3B49394BA9ABD9D;
    localparam logic [63:0]  C4_TAILS = 64'h8D8C8F8EBEBABDB9;
    localparam logic [79:0]  C5_TAILS = 80'h88879594A1A0A5A4BEBD;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [u8ds_pkg::CHAR_W-1:0] cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [u8ds_pkg::BYTE_W-1:0] in_byte     = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [u8ds_pkg::CHAR_W-1:0] ascii_char;

    translit_scoreboard sb;
    bit                 calm        = 1'b0;
    int                 bytes_sent  = 0;
    int                 settings    = 1;
    int                 cycles      = 0;
    int                 stall_left  = 0;

    utf8_diacritic_stripper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ascii_char  (ascii_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, sometimes short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check output beats and throttle out_ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_char(ascii_char);
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    // Present one byte, hold it until accepted
    task automatic send_byte(input logic [u8ds_pkg::BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected character is out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(input logic [u8ds_pkg::CHAR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_repl(value);
        settings++;
    endtask

    // One random sequence: mostly well-formed text, some broken or noise
    task automatic send_random_seq();
        int                          r;
        int                          k;
        int                          n;
        logic [u8ds_pkg::BYTE_W-1:0] tail;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_byte(8'($urandom_range(1, 127)));
        else if (r < 65)
        begin
            k = $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0)
                tail = 8'($urandom_range(8'h80, 8'hBF));
            else if (k == 0)
                tail = C3_TAILS[8 * $urandom_range(0, 15) +: 8];
            else if (k == 1)
                tail = C4_TAILS[8 * $urandom_range(0, 7) +: 8];
            else
                tail = C5_TAILS[8 * $urandom_range(0, 9) +: 8];
            send_byte(u8ds_pkg::LEAD_BYTE_C3 + 8'(k));
            send_byte(tail);
        end
        else if (r < 78)
        begin
            // unsupported multi-byte character, sometimes cut by a terminator
            n = $urandom_range(1, 3);
            if (n == 1)
            begin
                k = $urandom_range(0, 28);
                send_byte(u8ds_pkg::PAT_2BYTE + 8'(k) + ((k >= 3) ? 8'd3 : 8'd0));
            end
            else if (n == 2)
                send_byte(u8ds_pkg::PAT_3BYTE + 8'($urandom_range(0, 15)));
            else
                send_byte(u8ds_pkg::PAT_4BYTE + 8'($urandom_range(0, 7)));
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(END_OF_STRING);
                else
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
        else if (r < 85)
            send_byte(END_OF_STRING);
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [u8ds_pkg::BYTE_W-1:0] directed_bytes [$];
        logic [u8ds_pkg::CHAR_W-1:0] repl_value;
        int                          start_count;

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain ASCII, one letter per lead, bad second bytes,
        // foreign leads with their tails, stray bytes, cut sequences
        directed_bytes = {8'h41, 8'h7F, 8'h01,
                          u8ds_pkg::LEAD_BYTE_C3, 8'hA1, u8ds_pkg::LEAD_BYTE_C4, 8'h8C,
                          u8ds_pkg::LEAD_BYTE_C5, 8'hBD,
                          u8ds_pkg::LEAD_BYTE_C3, 8'h41,
                          u8ds_pkg::LEAD_BYTE_C4, u8ds_pkg::LEAD_BYTE_C5,
                          8'hC2, 8'h41, 8'hE2, 8'h80, 8'hA6, 8'hF0, 8'h9F, 8'h98, 8'h80,
                          8'h80, 8'hFF, 8'hF8,
                          u8ds_pkg::LEAD_BYTE_C5, END_OF_STRING, 8'hE1, END_OF_STRING,
                          8'h7A, END_OF_STRING};
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain();

        // Random phases, one replacement setting each
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       repl_value = REPL_MIN;
                1:       repl_value = REPL_MAX;
                5:       repl_value = u8ds_pkg::REPL_RESET;
                default: repl_value = 7'($urandom_range(1, 126));
            endcase
            write_repl(repl_value);
            calm = (phase == 2);
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES)
                send_random_seq();
            drain();
        end

        $display("Drove %0d bytes under %0d replacement settings,", bytes_sent, settings);
        $display("with idle and stall gaps on both sides");
        $display("Checked %0d output characters, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
hdl/u8ds_pkg.sv
hdl/u8ds_decode.sv
hdl/utf8_diacritic_stripper.sv
test/tb_utf8_diacritic_stripper.sv
